// ----- rtl/ecou_pkg.sv -----
package ecou_pkg;

  // field widths
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned ANGLE_IN_W = 16;
  localparam int unsigned DIR_W      = 16;
  localparam int unsigned TSTEP_W    = 16;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned VEC_W      = 16;
  localparam int unsigned SENS_W     = 12;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PITCH = 2'd0;
  localparam logic [ACT_W-1:0] ACT_YAW   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MOVE  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_SET   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SENS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd1;

  localparam logic [SENS_W-1:0]  SENS_RESET  = 12'd256;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;
  localparam logic signed [POS_W-1:0] POS_X_RESET = -32'sd131072;

  // angles in 1/128 degree
  localparam logic signed [21:0] PITCH_MAX  = 22'sd11392;
  localparam logic signed [21:0] PITCH_MIN  = -22'sd11392;
  localparam logic signed [21:0] TURN_S     = 22'sd46080;
  localparam logic [15:0]        FULL_TURN  = 16'd46080;
  localparam logic [15:0]        QTR_TURN   = 16'd11520;
  localparam logic [15:0]        HALF_TURN  = 16'd23040;
  localparam logic [15:0]        TQTR_TURN  = 16'd34560;
  localparam logic [15:0]        OCT_TURN   = 16'd5760;

  // radian conversion: pi*2^30 = 45*OCT_Q + 26, 23040 = 45*512
  localparam logic [34:0] OCT_Q    = 35'd74961320;
  localparam logic [17:0] OCT_REM  = 18'd26;
  localparam logic [17:0] OCT_BIAS = 18'd11520;
  localparam logic [34:0] INV_45   = 35'(((64'd1 << 24) + 64'd44) / 64'd45);

  // reciprocals for the horner steps, exact for dividends below 2^30
  localparam logic [34:0] INV_6  = 35'(((64'd1 << 36) + 64'd5) / 64'd6);
  localparam logic [34:0] INV_12 = 35'(((64'd1 << 36) + 64'd11) / 64'd12);
  localparam logic [34:0] INV_20 = 35'(((64'd1 << 36) + 64'd19) / 64'd20);
  localparam logic [34:0] INV_30 = 35'(((64'd1 << 36) + 64'd29) / 64'd30);
  localparam logic [34:0] INV_42 = 35'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam logic [34:0] INV_56 = 35'(((64'd1 << 36) + 64'd55) / 64'd56);

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // reciprocal used by each even horner step
  function automatic logic [34:0] horner_inv(input logic [3:0] step);
    logic [34:0] r;
    case (step)
      4'd0:    r = INV_42;
      4'd2:    r = INV_20;
      4'd4:    r = INV_6;
      4'd6:    r = INV_56;
      4'd8:    r = INV_30;
      4'd10:   r = INV_12;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ecou_in_if.sv -----
interface ecou_in_if import ecou_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [ACT_W-1:0]             action;
  logic signed [ANGLE_IN_W-1:0] amount;
  logic signed [DIR_W-1:0]      dir_x;
  logic signed [DIR_W-1:0]      dir_y;
  logic signed [DIR_W-1:0]      dir_z;
  logic [TSTEP_W-1:0]           time_step;
  logic signed [POS_W-1:0]      loc_x;
  logic signed [POS_W-1:0]      loc_y;
  logic signed [POS_W-1:0]      loc_z;

  modport source (
    output valid, action, amount, dir_x, dir_y, dir_z, time_step, loc_x, loc_y, loc_z,
    input  ready
  );
  modport sink (
    input  valid, action, amount, dir_x, dir_y, dir_z, time_step, loc_x, loc_y, loc_z,
    output ready
  );
endinterface

// ----- rtl/ecou_out_if.sv -----
interface ecou_out_if import ecou_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic signed [VEC_W-1:0] fwd_x;
  logic signed [VEC_W-1:0] fwd_y;
  logic signed [VEC_W-1:0] fwd_z;
  logic signed [VEC_W-1:0] right_x;
  logic signed [VEC_W-1:0] right_y;
  logic signed [VEC_W-1:0] right_z;
  logic signed [VEC_W-1:0] up_x;
  logic signed [VEC_W-1:0] up_y;
  logic signed [VEC_W-1:0] up_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, fwd_x, fwd_y, fwd_z,
           right_x, right_y, right_z, up_x, up_y, up_z,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, fwd_x, fwd_y, fwd_z,
           right_x, right_y, right_z, up_x, up_y, up_z,
    output ready
  );
endinterface

// ----- rtl/euler_camera_orientation_unit.sv -----
// camera orientation unit: keeps pitch, yaw and position of a first-person camera
// in_ch carries one command item (rotate pitch, rotate yaw, move, set position)
// out_ch returns one item per command: position plus forward, right and up vectors
// cfg port writes look sensitivity (index 0) and move speed (index 1); the user writes
// them only while idle, the block does not enforce it; most products run through one
// shared 35x35 signed multiplier with a registered product, plus a 2-bit-per-cycle
// square root and a 1-bit-per-cycle divider
// steps from accept to result valid: set position computes sin and cos of pitch,
// then of yaw; rotate pitch and rotate yaw first update the angle (yaw with a mod 360
// wrap); move first takes the square root and three divisions, skipped for a zero
// direction; the sequencer takes no new item before it is through with the last one;
// in_ch.ready is high only while the sequencer is idle; a finished item sits in the
// output register until taken; the next item is accepted meanwhile and its result
// waits in the sequencer if out_ch stalls
// reset: pitch and yaw zero, position (-2, 0, 0), sensitivity and speed 1.0,
// no item pending
module euler_camera_orientation_unit import ecou_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ecou_in_if.sink               in_ch,
  ecou_out_if.source            out_ch
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_ANG_MUL, ST_ANG_ADD, ST_YAW_RED,
    ST_MV_SQ0, ST_MV_SQ1, ST_MV_SQ2, ST_MV_SQ3, ST_MV_CHK, ST_MV_SQRT,
    ST_MV_MUL, ST_MV_DINIT, ST_MV_DIV, ST_MV_ACC,
    ST_SC_START, ST_SC_X0, ST_SC_X1, ST_SC_X2, ST_SC_XX, ST_SC_XT,
    ST_SC_HM, ST_SC_HT, ST_SC_FIN,
    ST_VEC0, ST_VEC1, ST_VEC2, ST_VEC3, ST_VEC4, ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [SENS_W-1:0]  sens_q;
  logic [SPEED_W-1:0] speed_q;

  // camera state
  logic signed [14:0]      pitch_q;
  logic [15:0]             yaw_q;
  logic signed [POS_W-1:0] pos_q [3];

  // latched item
  logic [ACT_W-1:0]         act_q;
  logic signed [15:0]       amt_q;
  logic signed [DIR_W-1:0]  dir_q [3];
  logic [TSTEP_W-1:0]       ts_q;

  // shared multiplier
  logic signed [34:0] mul_a;
  logic signed [34:0] mul_b;
  logic signed [69:0] mul_p;
  logic signed [69:0] prod_q;

  // angle update
  logic signed [21:0] ytmp_q;
  logic signed [28:0] ang_sum;
  logic signed [20:0] ang_dlt;
  logic signed [21:0] pitch_sum;
  logic signed [21:0] yaw_sum;

  // move
  logic [31:0] sq_q;
  logic [31:0] sdt_q;
  logic [47:0] rad_q;
  logic [23:0] root_q;
  logic [26:0] srem_q;
  logic [26:0] sq_rem;
  logic [26:0] sq_trial;
  logic [5:0]  cnt_q;
  logic [1:0]  axis_q;
  logic        neg_q;
  logic [47:0] dq_q;
  logic [23:0] drem_q;
  logic [24:0] dv_rem;
  logic        dv_ge;
  logic signed [47:0] mv_num;
  logic [47:0] mv_mag;
  logic signed [49:0] mv_step;
  logic signed [49:0] mv_sum;

  // sin and cos
  logic        sel_q;
  logic [15:0] sc_ang;
  logic [1:0]  sc_quad;
  logic [15:0] sc_t;
  logic [12:0] t_q;
  logic        swap_q;
  logic [1:0]  quad_q;
  logic [17:0] sc_r0;
  logic [39:0] tq_q;
  logic [40:0] x_sum;
  logic [29:0] x_q;
  logic [29:0] x2_q;
  logic [30:0] acc_q;
  logic [29:0] hv_q;
  logic [3:0]  hstep_q;
  logic [30:0] sin0_q;
  logic [30:0] cos0_q;
  logic signed [31:0] s0_v;
  logic signed [31:0] c0_v;
  logic signed [31:0] s_fin;
  logic signed [31:0] c_fin;
  logic signed [31:0] sp_q;
  logic signed [31:0] cp_q;
  logic signed [31:0] sy_q;
  logic signed [31:0] cy_q;

  // vector products
  logic signed [VEC_W-1:0] fx_q;
  logic signed [VEC_W-1:0] fz_q;
  logic signed [VEC_W-1:0] ux_q;
  logic signed [VEC_W-1:0] uz_q;

  // output register
  logic                    out_valid_q;
  logic signed [POS_W-1:0] out_pos_q [3];
  logic signed [VEC_W-1:0] out_fwd_q [3];
  logic signed [VEC_W-1:0] out_rgt_q [3];
  logic signed [VEC_W-1:0] out_up_q [3];

  // round a Q60 product to Q14, ties up
  function automatic logic [VEC_W-1:0] rnd46(input logic signed [69:0] v);
    logic signed [69:0] s;
    s = v + (70'sd1 <<< 45);
    return s[61:46];
  endfunction

  // round a Q30 value to Q14, ties up
  function automatic logic [VEC_W-1:0] rnd16(input logic signed [32:0] v);
    logic signed [32:0] s;
    s = v + 33'sd32768;
    return s[31:16];
  endfunction

  assign in_ch.ready = (state_q == ST_IDLE);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_ANG_MUL: begin
        mul_a = {{19{amt_q[15]}}, amt_q};
        mul_b = {23'b0, sens_q};
      end
      ST_MV_SQ0: begin
        mul_a = {{19{dir_q[0][15]}}, dir_q[0]};
        mul_b = {{19{dir_q[0][15]}}, dir_q[0]};
      end
      ST_MV_SQ1: begin
        mul_a = {{19{dir_q[1][15]}}, dir_q[1]};
        mul_b = {{19{dir_q[1][15]}}, dir_q[1]};
      end
      ST_MV_SQ2: begin
        mul_a = {{19{dir_q[2][15]}}, dir_q[2]};
        mul_b = {{19{dir_q[2][15]}}, dir_q[2]};
      end
      ST_MV_SQ3: begin
        mul_a = {19'b0, speed_q};
        mul_b = {19'b0, ts_q};
      end
      ST_MV_MUL: begin
        mul_a = {{19{dir_q[axis_q][15]}}, dir_q[axis_q]};
        mul_b = {3'b0, sdt_q};
      end
      ST_SC_X0: begin
        mul_a = {22'b0, t_q};
        mul_b = OCT_Q;
      end
      ST_SC_X1: begin
        mul_a = {17'b0, sc_r0};
        mul_b = INV_45;
      end
      ST_SC_XX: begin
        mul_a = {5'b0, x_q};
        mul_b = {5'b0, x_q};
      end
      ST_SC_HM: begin
        if (hstep_q[0]) begin
          // x2 (or x for the last sine step) times the running term
          mul_a = (hstep_q == 4'd5) ? {5'b0, x_q} : {5'b0, x2_q};
          mul_b = {4'b0, acc_q};
        end else begin
          // divide by a small constant through its reciprocal
          mul_a = (hstep_q == 4'd0 || hstep_q == 4'd6) ? {5'b0, x2_q} : {5'b0, hv_q};
          mul_b = horner_inv(hstep_q);
        end
      end
      ST_VEC0: begin
        mul_a = {{3{cy_q[31]}}, cy_q};
        mul_b = {{3{cp_q[31]}}, cp_q};
      end
      ST_VEC1: begin
        mul_a = {{3{sy_q[31]}}, sy_q};
        mul_b = {{3{cp_q[31]}}, cp_q};
      end
      ST_VEC2: begin
        mul_a = {{3{cy_q[31]}}, cy_q};
        mul_b = {{3{sp_q[31]}}, sp_q};
      end
      ST_VEC3: begin
        mul_a = {{3{sy_q[31]}}, sy_q};
        mul_b = {{3{sp_q[31]}}, sp_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
  end

  // angle delta: round(amount * sensitivity / 256), ties up
  assign ang_sum   = $signed(prod_q[28:0]) + 29'sd128;
  assign ang_dlt   = ang_sum[28:8];
  assign pitch_sum = {{7{pitch_q[14]}}, pitch_q} + {ang_dlt[20], ang_dlt};
  assign yaw_sum   = $signed({6'b0, yaw_q}) + {ang_dlt[20], ang_dlt};

  // square root step, two radicand bits per cycle
  assign sq_rem   = {srem_q[24:0], rad_q[47:46]};
  assign sq_trial = {1'b0, root_q, 2'b01};

  // restoring divide step
  assign dv_rem = {drem_q, dq_q[47]};
  assign dv_ge  = (dv_rem >= {1'b0, root_q});

  assign mv_num  = $signed(prod_q[47:0]);
  assign mv_mag  = mv_num[47] ? 48'(-mv_num) : 48'(mv_num);
  assign mv_step = neg_q ? -$signed({2'b0, dq_q}) : $signed({2'b0, dq_q});
  assign mv_sum  = {{18{pos_q[axis_q][31]}}, pos_q[axis_q]} + mv_step;

  // quadrant and octant fold of the current angle
  always_comb begin
    if (sel_q) begin
      sc_ang = yaw_q;
    end else if (pitch_q[14]) begin
      sc_ang = 16'({pitch_q[14], pitch_q}) + FULL_TURN;
    end else begin
      sc_ang = {1'b0, pitch_q};
    end
    if (sc_ang >= TQTR_TURN) begin
      sc_quad = 2'd3;
      sc_t    = sc_ang - TQTR_TURN;
    end else if (sc_ang >= HALF_TURN) begin
      sc_quad = 2'd2;
      sc_t    = sc_ang - HALF_TURN;
    end else if (sc_ang >= QTR_TURN) begin
      sc_quad = 2'd1;
      sc_t    = sc_ang - QTR_TURN;
    end else begin
      sc_quad = 2'd0;
      sc_t    = sc_ang;
    end
  end

  assign sc_r0 = ({5'b0, t_q} * OCT_REM) + OCT_BIAS;
  assign x_sum = {1'b0, tq_q} + {28'b0, prod_q[36:24]};

  // unfold to the full circle
  always_comb begin
    s0_v = swap_q ? $signed({1'b0, cos0_q}) : $signed({1'b0, sin0_q});
    c0_v = swap_q ? $signed({1'b0, sin0_q}) : $signed({1'b0, cos0_q});
    case (quad_q)
      2'd0: begin
        s_fin = s0_v;
        c_fin = c0_v;
      end
      2'd1: begin
        s_fin = c0_v;
        c_fin = -s0_v;
      end
      2'd2: begin
        s_fin = -s0_v;
        c_fin = -c0_v;
      end
      default: begin
        s_fin = -c0_v;
        c_fin = s0_v;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sens_q      <= SENS_RESET;
      speed_q     <= SPEED_RESET;
      pitch_q     <= '0;
      yaw_q       <= '0;
      pos_q[0]    <= POS_X_RESET;
      pos_q[1]    <= '0;
      pos_q[2]    <= '0;
      act_q       <= ACT_PITCH;
      amt_q       <= '0;
      dir_q[0]    <= '0;
      dir_q[1]    <= '0;
      dir_q[2]    <= '0;
      ts_q        <= '0;
      ytmp_q      <= '0;
      sq_q        <= '0;
      sdt_q       <= '0;
      rad_q       <= '0;
      root_q      <= '0;
      srem_q      <= '0;
      cnt_q       <= '0;
      axis_q      <= '0;
      neg_q       <= 1'b0;
      dq_q        <= '0;
      drem_q      <= '0;
      sel_q       <= 1'b0;
      t_q         <= '0;
      swap_q      <= 1'b0;
      quad_q      <= '0;
      tq_q        <= '0;
      x_q         <= '0;
      x2_q        <= '0;
      acc_q       <= '0;
      hv_q        <= '0;
      hstep_q     <= '0;
      sin0_q      <= '0;
      cos0_q      <= '0;
      sp_q        <= '0;
      cp_q        <= '0;
      sy_q        <= '0;
      cy_q        <= '0;
      fx_q        <= '0;
      fz_q        <= '0;
      ux_q        <= '0;
      uz_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        out_pos_q[i] <= '0;
        out_fwd_q[i] <= '0;
        out_rgt_q[i] <= '0;
        out_up_q[i]  <= '0;
      end
    end else begin
      // config writes; the user issues them only while idle, the block does not enforce it
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SENS:  sens_q  <= cfg_data_i[SENS_W-1:0];
          CFG_SPEED: speed_q <= cfg_data_i[SPEED_W-1:0];
          default:   ;
        endcase
      end

      if (out_valid_q && out_ch.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_ch.valid) begin
            act_q    <= in_ch.action;
            amt_q    <= in_ch.amount;
            dir_q[0] <= in_ch.dir_x;
            dir_q[1] <= in_ch.dir_y;
            dir_q[2] <= in_ch.dir_z;
            ts_q     <= in_ch.time_step;
            sel_q    <= 1'b0;
            case (in_ch.action)
              ACT_PITCH, ACT_YAW: state_q <= ST_ANG_MUL;
              ACT_MOVE:           state_q <= ST_MV_SQ0;
              default: begin
                pos_q[0] <= in_ch.loc_x;
                pos_q[1] <= in_ch.loc_y;
                pos_q[2] <= in_ch.loc_z;
                state_q  <= ST_SC_START;
              end
            endcase
          end
        end

        // rotation
        ST_ANG_MUL: state_q <= ST_ANG_ADD;
        ST_ANG_ADD: begin
          if (act_q == ACT_PITCH) begin
            if (pitch_sum > PITCH_MAX) begin
              pitch_q <= PITCH_MAX[14:0];
            end else if (pitch_sum < PITCH_MIN) begin
              pitch_q <= PITCH_MIN[14:0];
            end else begin
              pitch_q <= pitch_sum[14:0];
            end
            state_q <= ST_SC_START;
          end else begin
            ytmp_q  <= yaw_sum;
            state_q <= ST_YAW_RED;
          end
        end
        ST_YAW_RED: begin
          // wrap one turn per cycle
          if (ytmp_q < 0) begin
            ytmp_q <= ytmp_q + TURN_S;
          end else if (ytmp_q >= TURN_S) begin
            ytmp_q <= ytmp_q - TURN_S;
          end else begin
            yaw_q   <= ytmp_q[15:0];
            state_q <= ST_SC_START;
          end
        end

        // move: squared length, then sqrt, then one division per axis
        ST_MV_SQ0: state_q <= ST_MV_SQ1;
        ST_MV_SQ1: begin
          sq_q    <= prod_q[31:0];
          state_q <= ST_MV_SQ2;
        end
        ST_MV_SQ2: begin
          sq_q    <= sq_q + prod_q[31:0];
          state_q <= ST_MV_SQ3;
        end
        ST_MV_SQ3: begin
          sq_q    <= sq_q + prod_q[31:0];
          state_q <= ST_MV_CHK;
        end
        ST_MV_CHK: begin
          sdt_q  <= prod_q[31:0];
          rad_q  <= {sq_q, 16'b0};
          root_q <= '0;
          srem_q <= '0;
          cnt_q  <= 6'd23;
          // zero direction leaves the position alone
          state_q <= (sq_q == '0) ? ST_SC_START : ST_MV_SQRT;
        end
        ST_MV_SQRT: begin
          if (sq_rem >= sq_trial) begin
            srem_q <= sq_rem - sq_trial;
            root_q <= {root_q[22:0], 1'b1};
          end else begin
            srem_q <= sq_rem;
            root_q <= {root_q[22:0], 1'b0};
          end
          rad_q <= {rad_q[45:0], 2'b00};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            axis_q  <= '0;
            state_q <= ST_MV_MUL;
          end
        end
        ST_MV_MUL: state_q <= ST_MV_DINIT;
        ST_MV_DINIT: begin
          // magnitude plus half the length gives round half away from zero
          neg_q   <= mv_num[47];
          dq_q    <= mv_mag + {25'b0, root_q[23:1]};
          drem_q  <= '0;
          cnt_q   <= 6'd47;
          state_q <= ST_MV_DIV;
        end
        ST_MV_DIV: begin
          drem_q <= dv_ge ? 24'(dv_rem - {1'b0, root_q}) : dv_rem[23:0];
          dq_q   <= {dq_q[46:0], dv_ge};
          cnt_q  <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            state_q <= ST_MV_ACC;
          end
        end
        ST_MV_ACC: begin
          if (mv_sum > 50'sh7FFF_FFFF) begin
            pos_q[axis_q] <= 32'sh7FFF_FFFF;
          end else if (mv_sum < -50'sh8000_0000) begin
            pos_q[axis_q] <= -32'sh8000_0000;
          end else begin
            pos_q[axis_q] <= mv_sum[31:0];
          end
          if (axis_q == 2'd2) begin
            state_q <= ST_SC_START;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= ST_MV_MUL;
          end
        end

        // sin and cos of pitch, then of yaw
        ST_SC_START: begin
          quad_q  <= sc_quad;
          swap_q  <= (sc_t > OCT_TURN);
          t_q     <= (sc_t > OCT_TURN) ? 13'(QTR_TURN - sc_t) : sc_t[12:0];
          state_q <= ST_SC_X0;
        end
        ST_SC_X0: state_q <= ST_SC_X1;
        ST_SC_X1: begin
          tq_q    <= prod_q[39:0];
          state_q <= ST_SC_X2;
        end
        ST_SC_X2: begin
          x_q     <= x_sum[38:9];
          state_q <= ST_SC_XX;
        end
        ST_SC_XX: state_q <= ST_SC_XT;
        ST_SC_XT: begin
          x2_q    <= prod_q[59:30];
          hstep_q <= '0;
          state_q <= ST_SC_HM;
        end
        ST_SC_HM: state_q <= ST_SC_HT;
        ST_SC_HT: begin
          if (!hstep_q[0]) begin
            acc_q <= ONE_Q30 - {1'b0, prod_q[65:36]};
          end else if (hstep_q == 4'd5) begin
            sin0_q <= {1'b0, prod_q[59:30]};
          end else if (hstep_q == 4'd11) begin
            cos0_q <= ONE_Q30 - {2'b0, prod_q[59:31]};
          end else begin
            hv_q <= prod_q[59:30];
          end
          if (hstep_q == 4'd11) begin
            state_q <= ST_SC_FIN;
          end else begin
            hstep_q <= hstep_q + 4'd1;
            state_q <= ST_SC_HM;
          end
        end
        ST_SC_FIN: begin
          if (!sel_q) begin
            sp_q    <= s_fin;
            cp_q    <= c_fin;
            sel_q   <= 1'b1;
            state_q <= ST_SC_START;
          end else begin
            sy_q    <= s_fin;
            cy_q    <= c_fin;
            state_q <= ST_VEC0;
          end
        end

        // forward and up products
        ST_VEC0: state_q <= ST_VEC1;
        ST_VEC1: begin
          fx_q    <= rnd46(prod_q);
          state_q <= ST_VEC2;
        end
        ST_VEC2: begin
          fz_q    <= rnd46(prod_q);
          state_q <= ST_VEC3;
        end
        ST_VEC3: begin
          ux_q    <= rnd46(-prod_q);
          state_q <= ST_VEC4;
        end
        ST_VEC4: begin
          uz_q    <= rnd46(-prod_q);
          state_q <= ST_DONE;
        end

        // hand the item over once the output register is free
        ST_DONE: begin
          if (!out_valid_q || out_ch.ready) begin
            out_valid_q  <= 1'b1;
            out_pos_q[0] <= pos_q[0];
            out_pos_q[1] <= pos_q[1];
            out_pos_q[2] <= pos_q[2];
            out_fwd_q[0] <= fx_q;
            out_fwd_q[1] <= rnd16({sp_q[31], sp_q});
            out_fwd_q[2] <= fz_q;
            out_rgt_q[0] <= rnd16(-{sy_q[31], sy_q});
            out_rgt_q[1] <= '0;
            out_rgt_q[2] <= rnd16({cy_q[31], cy_q});
            out_up_q[0]  <= ux_q;
            out_up_q[1]  <= rnd16({cp_q[31], cp_q});
            out_up_q[2]  <= uz_q;
            state_q      <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.pos_x   = out_pos_q[0];
  assign out_ch.pos_y   = out_pos_q[1];
  assign out_ch.pos_z   = out_pos_q[2];
  assign out_ch.fwd_x   = out_fwd_q[0];
  assign out_ch.fwd_y   = out_fwd_q[1];
  assign out_ch.fwd_z   = out_fwd_q[2];
  assign out_ch.right_x = out_rgt_q[0];
  assign out_ch.right_y = out_rgt_q[1];
  assign out_ch.right_z = out_rgt_q[2];
  assign out_ch.up_x    = out_up_q[0];
  assign out_ch.up_y    = out_up_q[1];
  assign out_ch.up_z    = out_up_q[2];

endmodule
